// ----- design/crdg_pkg.sv -----
// Shared types and constants for the camera ray direction generator.
// Used by crdg_nr_step and camera_ray_direction_generator_top; no dependencies.
package crdg_pkg;

  localparam int unsigned LaneW  = 20;   // packed vector component width
  localparam int unsigned MagW   = 35;   // unnormalized component magnitude
  localparam int unsigned LenW   = 6;    // bit length of a magnitude
  localparam int unsigned MantW  = 15;   // normalized magnitude
  localparam int unsigned SumW   = 30;   // sum of squares after range adjust
  localparam int unsigned RecW   = 17;   // reciprocal square root estimate
  localparam int unsigned IdxW   = 30;   // ray buffer index
  localparam int unsigned SmpW   = 7;    // sample counter
  localparam int unsigned DirW   = 16;

  localparam logic [2:0] RegOrigin = 3'd0;
  localparam logic [2:0] RegCorner = 3'd1;
  localparam logic [2:0] RegColStp = 3'd2;
  localparam logic [2:0] RegRowStp = 3'd3;
  localparam logic [2:0] RegWidth  = 3'd4;
  localparam logic [2:0] RegHeight = 3'd5;
  localparam logic [2:0] RegSmpCnt = 3'd6;

  // Item moving through the normalization pipeline.
  typedef struct packed {
    logic                       valid;
    logic [2:0][MantW-1:0]      m;
    logic [2:0]                 neg;
    logic                       zero;
    logic                       e;
    logic [SumW-1:0]            s;
    logic [RecW-1:0]            y;
    logic [IdxW-1:0]            base;
    logic                       oof;
  } crdg_ray_t;

  function automatic logic [RecW-1:0] seed_lookup(input logic [3:0] idx);
    logic [RecW-1:0] r;
    case (idx)
      4'd5:    r = 17'd55889;
      4'd6:    r = 17'd51411;
      4'd7:    r = 17'd47861;
      4'd8:    r = 17'd44957;
      4'd9:    r = 17'd42525;
      4'd10:   r = 17'd40450;
      4'd11:   r = 17'd38651;
      4'd12:   r = 17'd37073;
      4'd13:   r = 17'd35673;
      4'd14:   r = 17'd34421;
      4'd15:   r = 17'd33292;
      default: r = 17'd61789;
    endcase
    return r;
  endfunction

endpackage

// ----- design/crdg_nr_step.sv -----
// One Newton-Raphson step of the reciprocal square root, three register stages.
// Depends on crdg_pkg (crdg_ray_t).
module crdg_nr_step import crdg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  crdg_ray_t din,
  output crdg_ray_t dout
);

  crdg_ray_t a_r, b_r, c_r;
  logic [17:0] pa_r;
  logic [33:0] h_r;
  logic [33:0] yy;
  logic [47:0] sp;
  logic [48:0] yt;
  logic [31:0] t;
  crdg_ray_t c_nxt;

  assign yy = {17'd0, din.y} * {17'd0, din.y};
  assign sp = {18'd0, a_r.s} * {30'd0, pa_r};
  assign t  = 32'hC000_0000 - h_r[31:0];
  assign yt = {32'd0, b_r.y} * {17'd0, t};

  always_comb begin
    c_nxt = b_r;
    if (h_r >= 34'h0_C000_0000) begin
      c_nxt.y = '0;
    end else begin
      c_nxt.y = yt[47:31];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.valid <= 1'b0;
      b_r.valid <= 1'b0;
      c_r.valid <= 1'b0;
    end else if (en) begin
      a_r  <= din;
      pa_r <= yy[33:16];
      b_r  <= a_r;
      h_r  <= sp[47:14];
      c_r  <= c_nxt;
    end
  end

  assign dout = c_r;

endmodule

// ----- design/camera_ray_direction_generator_top.sv -----
// Pinhole camera ray generator: pixel in, sample_count normalized rays out.
// Depends on crdg_pkg and crdg_nr_step.
//
//  channel | dir | handshake           | payload
//  in_     | in  | tvalid/tready       | tdata: pixel_col, pixel_row
//  out_    | out | tvalid/tready/tlast | tdata: dirs, origin, index; tuser: out_of_frame
//  cfg_    | in  | APB psel/penable    | 64-bit registers at 8*i
//
// The input passes through S1 to S6, the Newton steps, F1, F2 and the output register.
// Each pixel holds the output register until its sample_count rays are sent; with one
// sample a pixel is taken every cycle while out_tready is high. The whole pipeline
// advances together and holds while the output register still has rays of its pixel
// to send. Reset is synchronous; it clears the valid bits and loads register defaults.
module camera_ray_direction_generator_top import crdg_pkg::*; #(
  parameter int unsigned MAX_SIDE         = 4096,
  parameter int unsigned MAX_SAMPLES      = 64,
  parameter int unsigned RSQRT_ITERATIONS = 3
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [23:0]  in_tdata,     // [11:0] pixel_col, [23:12] pixel_row
  output logic         out_tvalid,
  input  logic         out_tready,
  // [15:0] dir_x, [31:16] dir_y, [47:32] dir_z, [67:48] orig_x,
  // [87:68] orig_y, [107:88] orig_z, [137:108] ray_index, [143:138] zero
  output logic [143:0] out_tdata,
  output logic         out_tlast,    // last_sample
  output logic         out_tuser,    // [0] out_of_frame
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [5:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);

  // ---------------- configuration ----------------
  logic [59:0] origin_r, corner_r, colstp_r, rowstp_r;
  logic [12:0] width_r, height_r;
  logic [6:0]  smpcnt_r;
  logic [2:0]  ridx;
  logic        wr;

  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[5:3];
  assign wr   = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r <= '0;
      corner_r <= '0;
      colstp_r <= '0;
      rowstp_r <= '0;
      width_r  <= 13'd1;
      height_r <= 13'd1;
      smpcnt_r <= 7'd1;
    end else if (wr) begin
      case (ridx)
        RegOrigin: origin_r <= cfg_pwdata[59:0];
        RegCorner: corner_r <= cfg_pwdata[59:0];
        RegColStp: colstp_r <= cfg_pwdata[59:0];
        RegRowStp: rowstp_r <= cfg_pwdata[59:0];
        RegWidth:  width_r  <= cfg_pwdata[12:0];
        RegHeight: height_r <= cfg_pwdata[12:0];
        RegSmpCnt: smpcnt_r <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      RegOrigin: cfg_prdata = {4'd0, origin_r};
      RegCorner: cfg_prdata = {4'd0, corner_r};
      RegColStp: cfg_prdata = {4'd0, colstp_r};
      RegRowStp: cfg_prdata = {4'd0, rowstp_r};
      RegWidth:  cfg_prdata = {51'd0, width_r};
      RegHeight: cfg_prdata = {51'd0, height_r};
      RegSmpCnt: cfg_prdata = {57'd0, smpcnt_r};
      default:   cfg_prdata = '0;
    endcase
  end

  logic [12:0]     w_eff;
  logic [SmpW-1:0] n_eff;

  always_comb begin
    if ({19'd0, width_r} > 32'(MAX_SIDE)) w_eff = 13'(MAX_SIDE);
    else                                  w_eff = width_r;
    if (smpcnt_r == '0)                                n_eff = 7'd1;
    else if ({25'd0, smpcnt_r} > 32'(MAX_SAMPLES))     n_eff = SmpW'(MAX_SAMPLES);
    else                                               n_eff = smpcnt_r;
  end

  // ---------------- pipeline control ----------------
  logic            en;
  logic            ov_r;
  logic [SmpW-1:0] k_r;
  logic            last_now;

  assign last_now  = (k_r + 7'd1 == n_eff);
  assign en        = !ov_r || (out_tready && last_now);
  assign in_tready = en;

  // ---------------- S1: lane products ----------------
  logic [11:0] col, row;
  logic [13:0] c2, r2;
  logic        v1_r, oof1_r;
  logic [11:0] col1_r;
  logic [24:0] rw1_r;
  logic signed [2:0][33:0] cx1_r, ry1_r;
  logic signed [2:0][LaneW-1:0] cor1_r;

  assign col = in_tdata[11:0];
  assign row = in_tdata[23:12];
  assign c2  = {1'b0, col, 1'b1};
  assign r2  = {1'b0, row, 1'b1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r   <= in_tvalid;
      col1_r <= col;
      rw1_r  <= {13'd0, row} * {12'd0, w_eff};
      oof1_r <= ({1'b0, col} >= w_eff) || ({1'b0, row} >= height_r);
      for (int k = 0; k < 3; k++) begin
        cx1_r[k]  <= $signed(c2) * $signed(colstp_r[k*LaneW +: LaneW]);
        ry1_r[k]  <= $signed(r2) * $signed(rowstp_r[k*LaneW +: LaneW]);
        cor1_r[k] <= corner_r[k*LaneW +: LaneW];
      end
    end
  end

  // ---------------- S2: sum, magnitude ----------------
  logic v2_r, oof2_r;
  logic [24:0] base2_r;
  logic [2:0][MagW-1:0] mag2_r;
  logic [2:0] neg2_r;
  logic signed [2:0][35:0] d2;
  logic [2:0][35:0] a2;

  // Elements of a packed array read as unsigned: sign-extend each lane.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d2[k] = 36'($signed(cor1_r[k])) * 36'sd2 + 36'($signed(cx1_r[k]))
            + 36'($signed(ry1_r[k]));
      a2[k] = d2[k][35] ? 36'(-d2[k]) : d2[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r    <= v1_r;
      oof2_r  <= oof1_r;
      base2_r <= rw1_r + {13'd0, col1_r};
      for (int k = 0; k < 3; k++) begin
        mag2_r[k] <= a2[k][MagW-1:0];
        neg2_r[k] <= d2[k][35];
      end
    end
  end

  // ---------------- S3: bit length of the largest magnitude ----------------
  logic v3_r, oof3_r, zero3_r;
  logic [24:0] base3_r;
  logic [2:0][MagW-1:0] mag3_r;
  logic [2:0] neg3_r;
  logic [LenW-1:0] len3_r;
  logic [MagW-1:0] any;
  logic [LenW-1:0] len;

  assign any = mag2_r[0] | mag2_r[1] | mag2_r[2];

  always_comb begin
    len = '0;
    for (int b = 0; b < MagW; b++) begin
      if (any[b]) len = LenW'(b + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r    <= v2_r;
      oof3_r  <= oof2_r;
      base3_r <= base2_r;
      mag3_r  <= mag2_r;
      neg3_r  <= neg2_r;
      zero3_r <= (any == '0);
      len3_r  <= len;
    end
  end

  // ---------------- S4: shift to 15 bits, index times samples ----------------
  logic v4_r, oof4_r, zero4_r;
  logic [IdxW-1:0] base4_r;
  logic [2:0][MantW-1:0] m4_r;
  logic [2:0] neg4_r;
  logic [31:0] bn;
  logic [2:0][MantW-1:0] m4;
  logic [MagW-1:0] shr;

  assign bn = {7'd0, base3_r} * {25'd0, n_eff};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (len3_r > LenW'(MantW)) begin
        shr   = mag3_r[k] >> (len3_r - LenW'(MantW));
        m4[k] = shr[MantW-1:0];
      end else begin
        shr   = mag3_r[k] << (LenW'(MantW) - len3_r);
        m4[k] = shr[MantW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r    <= v3_r;
      oof4_r  <= oof3_r;
      zero4_r <= zero3_r;
      base4_r <= bn[IdxW-1:0];
      m4_r    <= m4;
      neg4_r  <= neg3_r;
    end
  end

  // ---------------- S5: squares ----------------
  logic v5_r, oof5_r, zero5_r;
  logic [IdxW-1:0] base5_r;
  logic [2:0][MantW-1:0] m5_r;
  logic [2:0] neg5_r;
  logic [2:0][29:0] sq5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r    <= v4_r;
      oof5_r  <= oof4_r;
      zero5_r <= zero4_r;
      base5_r <= base4_r;
      m5_r    <= m4_r;
      neg5_r  <= neg4_r;
      for (int k = 0; k < 3; k++) begin
        sq5_r[k] <= {15'd0, m4_r[k]} * {15'd0, m4_r[k]};
      end
    end
  end

  // ---------------- S6: sum of squares, range adjust, seed ----------------
  crdg_ray_t s6_r, s6_nxt;
  logic [31:0] ssum;

  assign ssum = {2'd0, sq5_r[0]} + {2'd0, sq5_r[1]} + {2'd0, sq5_r[2]};

  always_comb begin
    s6_nxt.valid = v5_r;
    s6_nxt.m     = m5_r;
    s6_nxt.neg   = neg5_r;
    s6_nxt.zero  = zero5_r;
    s6_nxt.base  = base5_r;
    s6_nxt.oof   = oof5_r;
    if (ssum >= 32'h4000_0000) begin
      s6_nxt.e = 1'b1;
      s6_nxt.s = ssum[31:2];
    end else begin
      s6_nxt.e = 1'b0;
      s6_nxt.s = ssum[29:0];
    end
    s6_nxt.y = seed_lookup(s6_nxt.s[29:26]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_r.valid <= 1'b0;
    end else if (en) begin
      s6_r <= s6_nxt;
    end
  end

  // ---------------- Newton iterations ----------------
  crdg_ray_t nr [RSQRT_ITERATIONS+1];
  assign nr[0] = s6_r;

  for (genvar g = 0; g < RSQRT_ITERATIONS; g++) begin : g_nr
    crdg_nr_step u_step (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (en),
      .din  (nr[g]),
      .dout (nr[g+1])
    );
  end

  // ---------------- F1: scale ----------------
  crdg_ray_t f1_r;
  logic [2:0][31:0] pr1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_r.valid <= 1'b0;
    end else if (en) begin
      f1_r <= nr[RSQRT_ITERATIONS];
      for (int k = 0; k < 3; k++) begin
        pr1_r[k] <= {17'd0, nr[RSQRT_ITERATIONS].m[k]} * {15'd0, nr[RSQRT_ITERATIONS].y};
      end
    end
  end

  // ---------------- F2: round, saturate, sign ----------------
  logic f2v_r, f2oof_r;
  logic [IdxW-1:0] f2base_r;
  logic [2:0][DirW-1:0] f2dir_r;
  logic [2:0][DirW-1:0] dn;
  logic [32:0] rs;
  logic [17:0] rm;
  logic [14:0] rc;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (f1_r.e) rs = ({1'b0, pr1_r[k]} + 33'h0_0000_8000) >> 16;
      else        rs = ({1'b0, pr1_r[k]} + 33'h0_0000_4000) >> 15;
      rm = rs[17:0];
      rc = (rm > 18'd32767) ? 15'h7FFF : rm[14:0];
      if (f1_r.zero)          dn[k] = '0;
      else if (f1_r.neg[k])   dn[k] = 16'(-{1'b0, rc});
      else                    dn[k] = {1'b0, rc};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2v_r <= 1'b0;
    end else if (en) begin
      f2v_r    <= f1_r.valid;
      f2oof_r  <= f1_r.oof;
      f2base_r <= f1_r.base;
      f2dir_r  <= dn;
    end
  end

  // ---------------- output register, one ray per cycle while out_tready is high ----------------
  logic [IdxW-1:0] obase_r;
  logic [2:0][DirW-1:0] odir_r;
  logic ooof_r;
  logic [IdxW-1:0] ray_index;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      k_r  <= '0;
    end else if (en) begin
      ov_r    <= f2v_r;
      k_r     <= '0;
      obase_r <= f2base_r;
      odir_r  <= f2dir_r;
      ooof_r  <= f2oof_r;
    end else if (out_tready) begin
      k_r <= k_r + 7'd1;
    end
  end

  assign ray_index  = obase_r + {23'd0, k_r};
  assign out_tvalid = ov_r;
  assign out_tlast  = last_now;
  assign out_tuser  = ooof_r;
  assign out_tdata  = {6'd0, ray_index, origin_r, odir_r[2], odir_r[1], odir_r[0]};

  // ---------------- checks ----------------
  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (k_r < n_eff))
    else $error("sample counter beyond sample count");

  a_hold_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_tready && !last_now) |=> (ov_r && k_r == $past(k_r) + 7'd1))
    else $error("pixel dropped before its last ray");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(v1_r) && $stable(f2v_r)))
    else $error("pipeline moved during stall");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !ov_r |-> in_tready)
    else $error("input stalled with empty output register");

endmodule

// ----- test/testbench.sv -----
// Testbench for camera_ray_direction_generator_top: drives pixel items and
// register writes, predicts every ray and checks it. Depends on crdg_pkg.
`timescale 1ns / 1ps

module testbench;
  import crdg_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [23:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;
  logic         out_tlast;
  logic         out_tuser;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [5:0]   cfg_paddr = '0;
  logic [63:0]  cfg_pwdata = '0;
  logic [63:0]  cfg_prdata;
  logic         cfg_pready;

  typedef struct packed {
    logic [15:0] dir_x, dir_y, dir_z;
    logic [19:0] orig_x, orig_y, orig_z;
    logic [29:0] ray_index;
    logic        out_of_frame;
    logic        last_sample;
  } ray_t;

  // Predictor copy of the registers.
  logic [59:0] origin_reg, corner_reg, col_step_reg, row_step_reg;
  logic [12:0] width_reg, height_reg;
  logic [6:0]  samples_reg;

  ray_t   expected_rays[$];
  int     mismatches = 0;
  int     idle_pct = 30;
  bit     hold_off = 1'b0;
  int     quiet_cycles = 0;
  logic [15:0] seed_rom[16] = '{61789, 61789, 61789, 61789, 61789, 55889, 51411,
                                47861, 44957, 42525, 40450, 38651, 37073, 35673,
                                34421, 33292};

  camera_ray_direction_generator_top dut (.*);

  always #6 clk = ~clk;

  function automatic longint signed lane_of(logic [59:0] v, int k);
    return longint'(signed'(v[20*k +: 20]));
  endfunction

  function automatic logic [47:0] unit_direction(logic [11:0] col, logic [11:0] row);
    longint signed d[3];
    longint unsigned mag[3], m[3], mx, s, y, p, h, r, t;
    bit neg[3];
    int len, e;
    logic [47:0] res;
    mx = 0; s = 0; len = 0; e = 0; res = '0;
    for (int k = 0; k < 3; k++) begin
      d[k] = 2 * lane_of(corner_reg, k) + longint'(2 * col + 1) * lane_of(col_step_reg, k)
           + longint'(2 * row + 1) * lane_of(row_step_reg, k);
      neg[k] = d[k] < 0;
      mag[k] = neg[k] ? -d[k] : d[k];
      if (mag[k] > mx) mx = mag[k];
    end
    if (mx == 0) return '0;
    for (t = mx; t != 0; t = t >> 1) len++;
    for (int k = 0; k < 3; k++) begin
      m[k] = (len > 15) ? (mag[k] >> (len - 15)) : (mag[k] << (15 - len));
      s += m[k] * m[k];
    end
    if (s >= (64'd1 << 30)) begin
      s = s >> 2;
      e = 1;
    end
    y = seed_rom[(s >> 26) & 15];
    for (int it = 0; it < 3; it++) begin
      p = (y * y) >> 16;
      h = (s * p) >> 14;
      if (h >= (64'd3 << 30)) y = 0;
      else y = (y * ((64'd3 << 30) - h)) >> 31;
    end
    for (int k = 0; k < 3; k++) begin
      r = (m[k] * y + (64'd1 << (14 + e))) >> (15 + e);
      if (r > 32767) r = 32767;
      res[16*k +: 16] = neg[k] ? 16'(-r) : 16'(r);
    end
    return res;
  endfunction

  task automatic predict_rays(logic [11:0] col, logic [11:0] row);
    longint unsigned w, n, base;
    logic [47:0] dir;
    ray_t ray;
    w = (width_reg > 4096) ? 4096 : width_reg;
    n = (samples_reg == 0) ? 1 : (samples_reg > 64 ? 64 : samples_reg);
    dir = unit_direction(col, row);
    base = ((row * w + col) * n) & 30'h3FFFFFFF;
    for (int k = 0; k < n; k++) begin
      ray.dir_x = dir[15:0];
      ray.dir_y = dir[31:16];
      ray.dir_z = dir[47:32];
      ray.orig_x = origin_reg[19:0];
      ray.orig_y = origin_reg[39:20];
      ray.orig_z = origin_reg[59:40];
      ray.ray_index = 30'(base + k);
      ray.out_of_frame = (col >= w) || (row >= height_reg);
      ray.last_sample = (k + 1 == n);
      expected_rays.push_back(ray);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    @(negedge clk);
    cfg_psel = 1'b1; cfg_pwrite = 1'b1; cfg_paddr = {idx, 3'b000}; cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    case (idx)
      RegOrigin: origin_reg   = value[59:0];
      RegCorner: corner_reg   = value[59:0];
      RegColStp: col_step_reg = value[59:0];
      RegRowStp: row_step_reg = value[59:0];
      RegWidth:  width_reg    = value[12:0];
      RegHeight: height_reg   = value[12:0];
      RegSmpCnt: samples_reg  = value[6:0];
      default: ;
    endcase
  endtask

  // Wait for every ray, then for the pipeline to go quiet; end on a falling edge.
  task automatic drain;
    while (expected_rays.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);
  endtask

  // Called on a falling edge; returns on the falling edge after the accept.
  task automatic send_pixel(logic [11:0] col, logic [11:0] row);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {row, col};
    predict_rays(col, row);
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  function automatic logic [19:0] q415(int lo, int hi);
    return 20'($signed($urandom_range(hi - lo)) + lo);
  endfunction

  task automatic load_camera(int span, int w, int h, int n);
    write_reg(RegOrigin, {$urandom, $urandom});
    write_reg(RegCorner, {4'b0, q415(-span, span), q415(-span, span), q415(-span, span)});
    write_reg(RegColStp, {4'b0, q415(-span/64, span/64), q415(-span/64, span/64),
                          q415(-span/64, span/64)});
    write_reg(RegRowStp, {4'b0, q415(-span/64, span/64), q415(-span/64, span/64),
                          q415(-span/64, span/64)});
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
    write_reg(RegSmpCnt, n);
  endtask

  task automatic test_directed;
    send_pixel(0, 0);                       // reset registers: zero direction
    drain();
    load_camera(32768, 4096, 4096, 1);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);
    drain();
    // extreme vectors, largest magnitudes
    write_reg(RegCorner, {20'h80000, 20'h7FFFF, 20'h80000});
    write_reg(RegColStp, {20'h7FFFF, 20'h80000, 20'h7FFFF});
    write_reg(RegRowStp, {20'h80000, 20'h80000, 20'h7FFFF});
    write_reg(RegOrigin, 64'h0FFF_FFFF_FFFF_FFFF);
    send_pixel(4095, 0);
    send_pixel(0, 4095);
    send_pixel(4095, 4095);
    drain();
    // width above max side, zero sizes, zero and oversized sample counts
    write_reg(RegWidth, 13'h1FFF);
    write_reg(RegSmpCnt, 0);
    send_pixel(4095, 2);
    drain();
    write_reg(RegHeight, 0);
    write_reg(RegSmpCnt, 7'h7F);
    send_pixel(3, 3);
    drain();
    write_reg(RegWidth, 0);
    write_reg(RegHeight, 13'h1000);
    write_reg(RegSmpCnt, 64);
    send_pixel(1, 1);
    drain();
    // large index: big image with several samples
    write_reg(RegWidth, 4096);
    write_reg(RegSmpCnt, 3);
    send_pixel(4095, 4095);
    drain();
    write_reg(RegSmpCnt, 1);
    write_reg(RegCorner, {20'h0, 20'h0, 20'h00001});
    write_reg(RegColStp, 0);
    write_reg(RegRowStp, 0);
    send_pixel(0, 0);                       // tiny direction along one axis
    drain();
  endtask

  task automatic test_random(int count, int max_samples);
    int span, w, h;
    span = 1 << $urandom_range(19, 6);
    w = $urandom_range(1, 4096);
    h = $urandom_range(1, 4096);
    load_camera(span, w, h, $urandom_range(1, max_samples));
    for (int i = 0; i < count; i++)
      send_pixel($urandom_range(4095) % (w + 8), $urandom_range(4095) % (h + 8));
    drain();
  endtask

  task automatic test_backpressure;
    load_camera(32768, 64, 64, 1);
    hold_off = 1'b1;
    for (int i = 0; i < 40; i++) send_pixel($urandom_range(70), $urandom_range(70));
    drain();
  endtask

  // Ray checker.
  always @(posedge clk) begin
    ray_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[15:0], out_tdata[31:16], out_tdata[47:32], out_tdata[67:48],
             out_tdata[87:68], out_tdata[107:88], out_tdata[137:108], out_tuser, out_tlast};
      if (expected_rays.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected ray %h", got);
      end else begin
        want = expected_rays.pop_front();
        if (got !== want || out_tdata[143:138] !== '0) begin
          mismatches++;
          if (mismatches <= 10) $display("ray mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  // Receiver: random stalls; one long hold-off when asked.
  always @(negedge clk) begin
    if (hold_off) begin
      out_tready <= 1'b0;
      repeat (300) @(negedge clk);
      hold_off = 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    origin_reg = '0; corner_reg = '0; col_step_reg = '0; row_step_reg = '0;
    width_reg = 1; height_reg = 1; samples_reg = 1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    for (int p = 0; p < 6; p++) test_random(40, (p % 2) ? 64 : 4);
    idle_pct = 0;
    test_random(100, 1);                    // full-rate stretch, no idling
    idle_pct = 30;
    test_backpressure();
    if (mismatches == 0 && expected_rays.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
